[rtl/rc_receiver_frame_decoder_assert.svh]
// Assertion macros shared by the frame decoder modules.
// Each macro takes a label, the clock, the active-low reset, a trigger and a check.
`ifndef RC_RECEIVER_FRAME_DECODER_ASSERT_SVH
`define RC_RECEIVER_FRAME_DECODER_ASSERT_SVH

// Check holds in the same cycle as the trigger
`define RCFD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("rcfd: same-cycle check failed");

// Check holds in the cycle after the trigger
`define RCFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("rcfd: next-cycle check failed");

`endif

[rtl/rcfd_pkg.sv]
package rcfd_pkg;

  // Frame layout and key set
  localparam int FRAME_LEN = 18;
  localparam int BYTE_AW   = $clog2(FRAME_LEN);
  localparam int CNT_W     = 5;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  localparam int FLAG_W    = 18;
  localparam int KEY_NUM   = 18;
  localparam int TIMER_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CMP_W     = (TIMER_W > CFG_W) ? TIMER_W : CFG_W;

  // Channel decode
  localparam int CH_W        = 11;
  localparam int CH_OFFSET   = 1024;
  localparam int CH_LIMIT    = 660;
  localparam int CH_DEADBAND = 5;
  localparam logic [3:0] SW_LEFT_MASK  = 4'hC;
  localparam logic [3:0] SW_RIGHT_MASK = 4'h3;

  // Reset values of the thresholds
  localparam logic [CFG_W-1:0] PRESS_RST = CFG_W'(10);
  localparam logic [CFG_W-1:0] LONG_RST  = CFG_W'(50);

  // Command queue depth (power of two)
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    FUNC_DATA = 2'd0,
    FUNC_IDLE = 2'd1,
    FUNC_TICK = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  typedef enum logic {
    CMD_FRAME = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_ONLINE  = 2'd2,
    ST_OFFLINE = 2'd3
  } status_e;

  typedef enum logic {
    CFG_PRESS = 1'b0,
    CFG_LONG  = 1'b1
  } cfg_idx_e;

  // Classified request handed from the front to the back
  typedef struct packed {
    cmd_kind_e              kind;
    logic                   bad;
    logic signed [CH_W-1:0] stick0;
    logic signed [CH_W-1:0] stick1;
    logic signed [CH_W-1:0] stick2;
    logic signed [CH_W-1:0] stick3;
    logic signed [CH_W-1:0] dial;
    logic [3:0]             switches;
    logic signed [15:0]     mouse_dx;
    logic signed [15:0]     mouse_dy;
    logic [FLAG_W-1:0]      held;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic signed [CH_W-1:0] stick0;
    logic signed [CH_W-1:0] stick1;
    logic signed [CH_W-1:0] stick2;
    logic signed [CH_W-1:0] stick3;
    logic signed [CH_W-1:0] dial;
    logic [3:0]             switches;
    logic signed [15:0]     mouse_dx;
    logic signed [15:0]     mouse_dy;
    logic [FLAG_W-1:0]      press_flags;
    logic [FLAG_W-1:0]      long_flags;
    logic [FLAG_W-1:0]      click_flags;
    status_e                status;
  } res_t;

  // Center a raw channel and zero it inside the deadband
  function automatic logic signed [CH_W-1:0] center(input logic [CH_W-1:0] raw);
    logic signed [CH_W-1:0] v;
    v = signed'(raw - CH_W'(CH_OFFSET));
    if (v <= CH_DEADBAND && v >= -CH_DEADBAND) begin
      v = '0;
    end
    return v;
  endfunction

  function automatic logic out_of_range(input logic signed [CH_W-1:0] v);
    return (v > CH_LIMIT) || (v < -CH_LIMIT);
  endfunction

endpackage

[rtl/rcfd_front.sv]
`include "rc_receiver_frame_decoder_assert.svh"

module rcfd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    in_func_i,
  input  logic [7:0]    in_data_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output rcfd_pkg::cmd_t q_cmd_o
);
  import rcfd_pkg::*;

  logic [7:0]       bytes_q [FRAME_LEN];
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             accept;
  func_e            func;
  logic [CH_W-1:0]  raw0, raw1, raw2, raw3, raw4;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign func       = func_e'(in_func_i);

  // Store bytes of the current burst; entries past the frame are dropped
  always_ff @(posedge clk_i) begin
    if (accept && func == FUNC_DATA && cnt_q < CNT_W'(FRAME_LEN)) begin
      bytes_q[cnt_q[BYTE_AW-1:0]] <= in_data_i;
    end
  end

  // Count bytes, saturate, and restart on line idle
  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      case (func)
        FUNC_DATA: if (cnt_q != COUNT_MAX) cnt_d = cnt_q + CNT_W'(1);
        FUNC_IDLE: cnt_d = '0;
        default:   cnt_d = cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Queue a frame only when exactly one frame of bytes arrived; always queue a tick
  assign q_push_o = accept && ((func == FUNC_TICK) ||
                               (func == FUNC_IDLE && cnt_q == CNT_W'(FRAME_LEN)));

  // Unpack channels from the stored bytes
  assign raw0 = {bytes_q[1][2:0], bytes_q[0]};
  assign raw1 = {bytes_q[2][5:0], bytes_q[1][7:3]};
  assign raw2 = {bytes_q[4][0], bytes_q[3], bytes_q[2][7:6]};
  assign raw3 = {bytes_q[5][3:0], bytes_q[4][7:1]};
  assign raw4 = {bytes_q[17][2:0], bytes_q[16]};

  always_comb begin
    q_cmd_o          = '0;
    q_cmd_o.kind     = (func == FUNC_TICK) ? CMD_TICK : CMD_FRAME;
    q_cmd_o.stick0   = center(raw0);
    q_cmd_o.stick1   = center(raw1);
    q_cmd_o.stick2   = center(raw2);
    q_cmd_o.stick3   = center(raw3);
    q_cmd_o.dial     = center(raw4);
    q_cmd_o.switches = (bytes_q[5][7:4] & SW_LEFT_MASK) | (bytes_q[5][7:4] & SW_RIGHT_MASK);
    q_cmd_o.mouse_dx = signed'({bytes_q[7], bytes_q[6]});
    q_cmd_o.mouse_dy = signed'({bytes_q[9], bytes_q[8]});
    q_cmd_o.held     = {(bytes_q[13] != 8'd0), (bytes_q[12] != 8'd0),
                        bytes_q[15], bytes_q[14]};
    q_cmd_o.bad      = out_of_range(q_cmd_o.stick0) || out_of_range(q_cmd_o.stick1) ||
                       out_of_range(q_cmd_o.stick2) || out_of_range(q_cmd_o.stick3) ||
                       out_of_range(q_cmd_o.dial);
  end

  `RCFD_ASSERT_NEXT(a_idle_clears_count, clk_i, rst_ni, accept && func == FUNC_IDLE,
                    cnt_q == '0)
  `RCFD_ASSERT_NOW(a_push_needs_room, clk_i, rst_ni, q_push_o, !q_full_i)

endmodule

[rtl/rcfd_fifo.sv]
`include "rc_receiver_frame_decoder_assert.svh"

module rcfd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rcfd_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output rcfd_pkg::cmd_t cmd_o,
  output logic           empty_o
);
  import rcfd_pkg::*;

  cmd_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]   cnt_q;

  assign full_o  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  // Hold queued requests
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      cnt_q <= cnt_q + (FIFO_AW+1)'(push_i) - (FIFO_AW+1)'(pop_i);
    end
  end

  `RCFD_ASSERT_NOW(a_pop_needs_data, clk_i, rst_ni, pop_i, !empty_o)

endmodule

[rtl/rcfd_back.sv]
`include "rc_receiver_frame_decoder_assert.svh"

module rcfd_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [rcfd_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                    q_empty_i,
  input  rcfd_pkg::cmd_t          q_cmd_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output rcfd_pkg::res_t          out_res_o
);
  import rcfd_pkg::*;

  logic [CFG_W-1:0]   press_th_q, long_th_q;
  logic [TIMER_W-1:0] hold_q [KEY_NUM];
  logic [TIMER_W-1:0] hold_d [KEY_NUM];
  logic [TIMER_W-1:0] hold_inc [KEY_NUM];
  logic [FLAG_W-1:0]  press_q, press_d, long_q, long_d, click_q, click_d;
  logic               seen_q;
  logic               out_valid_q;
  res_t               res_q, res_d;
  logic               is_frame;

  // Take a request whenever the output register is free or being drained
  assign q_pop_o     = !q_empty_i && (!out_valid_q || out_ready_i);
  assign is_frame    = (q_cmd_i.kind == CMD_FRAME);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  // Threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_th_q <= PRESS_RST;
      long_th_q  <= LONG_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PRESS: press_th_q <= cfg_wdata_i;
        CFG_LONG:  long_th_q  <= cfg_wdata_i;
        default:   press_th_q <= press_th_q;
      endcase
    end
  end

  // Saturating increment of each hold timer
  always_comb begin
    for (int k = 0; k < KEY_NUM; k++) begin
      hold_inc[k] = (hold_q[k] != {TIMER_W{1'b1}}) ? hold_q[k] + TIMER_W'(1) : hold_q[k];
    end
  end

  // Update every key for one frame
  always_comb begin
    press_d = press_q;
    long_d  = long_q;
    click_d = click_q;
    for (int k = 0; k < KEY_NUM; k++) begin
      hold_d[k] = hold_q[k];
      if (q_cmd_i.held[k]) begin
        hold_d[k] = hold_inc[k];
        if (CMP_W'(hold_inc[k]) > CMP_W'(press_th_q)) press_d[k] = 1'b1;
        if (CMP_W'(hold_inc[k]) > CMP_W'(long_th_q))  long_d[k]  = 1'b1;
      end else begin
        click_d[k] = (CMP_W'(hold_q[k]) > CMP_W'(press_th_q)) &&
                     (CMP_W'(hold_q[k]) < CMP_W'(long_th_q));
        press_d[k] = 1'b0;
        long_d[k]  = 1'b0;
        hold_d[k]  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < KEY_NUM; k++) begin
        hold_q[k] <= '0;
      end
      press_q <= '0;
      long_q  <= '0;
      click_q <= '0;
      seen_q  <= 1'b0;
    end else if (q_pop_o) begin
      if (is_frame) begin
        hold_q  <= hold_d;
        press_q <= press_d;
        long_q  <= long_d;
        click_q <= click_d;
        seen_q  <= 1'b1;
      end else begin
        seen_q  <= 1'b0;
      end
    end
  end

  // Build the result for the request being taken
  always_comb begin
    res_d = '0;
    if (is_frame) begin
      res_d.stick0      = q_cmd_i.stick0;
      res_d.stick1      = q_cmd_i.stick1;
      res_d.stick2      = q_cmd_i.stick2;
      res_d.stick3      = q_cmd_i.stick3;
      res_d.dial        = q_cmd_i.dial;
      res_d.switches    = q_cmd_i.switches;
      res_d.mouse_dx    = q_cmd_i.mouse_dx;
      res_d.mouse_dy    = q_cmd_i.mouse_dy;
      res_d.press_flags = press_d;
      res_d.long_flags  = long_d;
      res_d.click_flags = click_d;
      res_d.status      = q_cmd_i.bad ? ST_RANGE : ST_OK;
    end else begin
      res_d.press_flags = press_q;
      res_d.long_flags  = long_q;
      res_d.click_flags = click_q;
      res_d.status      = seen_q ? ST_ONLINE : ST_OFFLINE;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  `RCFD_ASSERT_NEXT(a_tick_clears_seen, clk_i, rst_ni, q_pop_o && !is_frame, !seen_q)
  `RCFD_ASSERT_NEXT(a_pop_loads_output, clk_i, rst_ni, q_pop_o, out_valid_q)

endmodule

[rtl/rc_receiver_frame_decoder.sv]
// Radio-control receiver frame decoder.
// Input stream: one request per byte event. s_axis_tuser carries the event
// kind (data byte, line idle, supervision tick), s_axis_tdata the byte.
// Output stream: one result per decoded frame and one per tick; bursts of the
// wrong length at line idle produce nothing. m_axis_tuser carries the status.
// Thresholds are written through cfg_we_i/cfg_idx_i/cfg_wdata_i while idle:
// index 0 press threshold, index 1 long-press threshold.
// Throughput: one input request per cycle while the queue has room, one result
// per cycle while m_axis_tready is high. An accepted idle or tick request
// enters the two-entry queue; the back end pops it when the output register
// is free or being drained, runs the key update and loads the output register.
// Stall: the output register holds while m_axis_tready is low; the queue
// absorbs two more frame/tick requests, then s_axis_tready drops. Data bytes
// are taken only while the queue has room.
// Reset: byte count, key timers, flags and link status clear at once, the
// thresholds return to 10 and 50; no clearing pass is needed.
module rc_receiver_frame_decoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,    // [7:0] data
  input  logic [1:0]   s_axis_tuser,    // [1:0] func
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [10:0] stick0, [21:11] stick1, [32:22] stick2, [43:33] stick3, [54:44] dial,
  // [58:55] switches, [74:59] mouse_dx, [90:75] mouse_dy, [108:91] press_flags,
  // [126:109] long_flags, [144:127] click_flags, [151:145] zero
  output logic [151:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser,    // [1:0] status
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [rcfd_pkg::CFG_W-1:0] cfg_wdata_i
);
  import rcfd_pkg::*;

  cmd_t push_cmd, pop_cmd;
  logic push, pop, full, empty;
  res_t res;

  rcfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_func_i  (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_cmd_o    (push_cmd)
  );

  rcfd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (pop_cmd),
    .empty_o (empty)
  );

  rcfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_empty_i   (empty),
    .q_cmd_i     (pop_cmd),
    .q_pop_o     (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  // Pack the result, first field in the lowest bits
  assign m_axis_tdata = {7'b0, res.click_flags, res.long_flags, res.press_flags,
                         res.mouse_dy, res.mouse_dx, res.switches, res.dial,
                         res.stick3, res.stick2, res.stick1, res.stick0};
  assign m_axis_tuser = res.status;

endmodule
